[sv/opes_pkg.sv]
// ----------------------------------------------------------------------------
// opes_pkg
// Shared constants and tables for the odometry step core.
// ----------------------------------------------------------------------------
package opes_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ADDR_W = 4;

  localparam logic [ADDR_W-1:0] REG_TARGET_X = 4'h0;
  localparam logic [ADDR_W-1:0] REG_TARGET_Y = 4'h4;
  localparam logic [ADDR_W-1:0] REG_TARGET_ANGLE = 4'h8;

  localparam logic signed [31:0] CORDIC_K = 32'sd652032874;

  function automatic logic signed [23:0] atan_deg(input logic [3:0] i);
    logic signed [23:0] r;
    begin
      unique case (i)
        4'd0: r = 24'sd2949120;
        4'd1: r = 24'sd1740967;
        4'd2: r = 24'sd919879;
        4'd3: r = 24'sd466945;
        4'd4: r = 24'sd234379;
        4'd5: r = 24'sd117304;
        4'd6: r = 24'sd58666;
        4'd7: r = 24'sd29335;
        4'd8: r = 24'sd14668;
        4'd9: r = 24'sd7334;
        4'd10: r = 24'sd3667;
        4'd11: r = 24'sd1833;
        4'd12: r = 24'sd917;
        4'd13: r = 24'sd458;
        4'd14: r = 24'sd229;
        default: r = 24'sd115;
      endcase
      return r;
    end
  endfunction

endpackage

[sv/opes_if.sv]
// ----------------------------------------------------------------------------
// opes_in_if / opes_out_if
// Valid/ready channels of the odometry step core.
// ----------------------------------------------------------------------------
interface opes_in_if;
  logic valid;
  logic ready;
  logic signed [23:0] delta_length;
  logic signed [24:0] delta_angle;
  modport source (output valid, output delta_length, output delta_angle, input ready);
  modport sink (input valid, input delta_length, input delta_angle, output ready);
endinterface

interface opes_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] drive_distance;
  logic signed [26:0] drive_angle;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [24:0] pose_heading;
  modport source (output valid, output drive_distance, output drive_angle,
                  output pose_x, output pose_y, output pose_heading, input ready);
  modport sink (input valid, input drive_distance, input drive_angle,
                input pose_x, input pose_y, input pose_heading, output ready);
endinterface

[sv/opes_cordic.sv]
// ----------------------------------------------------------------------------
// opes_cordic
// Iterative CORDIC giving sine and cosine of a Q16 degree angle, one
// rotation per cycle.
// ----------------------------------------------------------------------------
module opes_cordic (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [26:0] angle,
  output logic done,
  output logic signed [31:0] sin_out,
  output logic signed [31:0] cos_out
);
  import opes_pkg::*;

  logic signed [32:0] x, y;
  logic signed [26:0] z;
  logic neg;
  logic [4:0] cnt;
  logic run;
  logic signed [32:0] xs, ys;
  logic [3:0] idx;

  assign idx = cnt[3:0];
  assign xs = x >>> idx;
  assign ys = y >>> idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        x <= 33'(CORDIC_K);
        y <= '0;
        if (angle > 27'sd5898240) begin
          z <= angle - 27'sd11796480;
          neg <= 1'b1;
        end else if (angle < -27'sd5898240) begin
          z <= angle + 27'sd11796480;
          neg <= 1'b1;
        end else begin
          z <= angle;
          neg <= 1'b0;
        end
      end else if (run) begin
        if (z >= 0) begin
          x <= x - ys;
          y <= y + xs;
          z <= z - 27'(atan_deg(idx));
        end else begin
          x <= x + ys;
          y <= y - xs;
          z <= z + 27'(atan_deg(idx));
        end
        cnt <= cnt + 5'd1;
        if (cnt == 5'(CORDIC_STEPS - 1)) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sin_out = neg ? -y[31:0] : y[31:0];
  assign cos_out = neg ? -x[31:0] : x[31:0];
endmodule

[sv/opes_mul.sv]
// ----------------------------------------------------------------------------
// opes_mul
// Shift-and-add multiplier, one bit of the 24-bit multiplier per cycle.
// ----------------------------------------------------------------------------
module opes_mul (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [23:0] a,
  input  logic signed [31:0] b,
  output logic done,
  output logic signed [55:0] prod
);
  logic [23:0] mq;
  logic signed [55:0] acc;
  logic signed [55:0] bsh;
  logic [4:0] cnt;
  logic run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        mq <= a;
        acc <= '0;
        bsh <= 56'(b);
      end else if (run) begin
        if (mq[0]) begin
          if (cnt == 5'd23) acc <= acc - bsh;
          else acc <= acc + bsh;
        end
        mq <= mq >> 1;
        bsh <= bsh <<< 1;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd23) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign prod = acc;
endmodule

[sv/opes_sqrt.sv]
// ----------------------------------------------------------------------------
// opes_sqrt
// Digit-recurrence integer square root of a 64-bit radicand, one result
// bit per cycle.
// ----------------------------------------------------------------------------
module opes_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [63:0] radicand,
  output logic done,
  output logic [31:0] root
);
  logic [63:0] rem;
  logic [63:0] r;
  logic [63:0] bitv;
  logic [5:0] cnt;
  logic run;
  logic [63:0] trial;

  assign trial = r + bitv;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
        rem <= radicand;
        r <= '0;
        bitv <= 64'h4000_0000_0000_0000;
      end else if (run) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          r <= (r >> 1) + bitv;
        end else begin
          r <= r >> 1;
        end
        bitv <= bitv >> 2;
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          run <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign root = r[31:0];
endmodule

[sv/odometry_position_error_step_core.sv]
// ----------------------------------------------------------------------------
// odometry_position_error_step_core
// Dead-reckoning odometry step with a position-error drive command.
//
// One input transaction carries a distance and a heading increment; it
// yields one output transaction with the drive distance, drive angle and the
// updated pose. Targets are to be written over the APB port only while idle;
// the core itself does not enforce this. When the distance increment moves
// the position, one controller runs in sequence a CORDIC and two serial
// multiplies for the position update; in every case it then runs two serial
// squarings of the errors and a square root, and then loads the output.
// One item is in work at a time; the input is ready again in the cycle after
// the result is loaded, so no new item is taken before then. A new item
// may run while the previous result is still held by a stalled receiver,
// and then waits until that result is taken before loading its own.
// Reset clears the pose, the targets and all control state.
// ----------------------------------------------------------------------------
module odometry_position_error_step_core #(
  parameter int FRAC_BITS = opes_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  opes_in_if.sink  in_ch,
  opes_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [opes_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import opes_pkg::*;

  localparam longint ANG_THR = ((64'sd1 <<< FRAC_BITS) + 5) / 10;
  localparam longint LEN_THR = ((64'sd1 <<< FRAC_BITS) + 500) / 1000;
  localparam longint FULL = 64'sd360 <<< FRAC_BITS;
  localparam longint HALF = 64'sd180 <<< FRAC_BITS;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_SC   = 8'b00000010,
    S_MS   = 8'b00000100,
    S_MC   = 8'b00001000,
    S_EX   = 8'b00010000,
    S_EY   = 8'b00100000,
    S_SQ   = 8'b01000000,
    S_OUT  = 8'b10000000
  } state_t;

  state_t state;
  logic signed [31:0] target_x, target_y;
  logic signed [24:0] target_angle;
  logic signed [31:0] cur_x, cur_y;
  logic signed [24:0] cur_heading;
  logic signed [23:0] dl;
  logic signed [31:0] s_val, c_val;
  logic [63:0] sumsq;
  logic signed [32:0] exr, eyr;
  logic backward, big;

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr)
      REG_TARGET_X: prdata = target_x;
      REG_TARGET_Y: prdata = target_y;
      REG_TARGET_ANGLE: prdata = 32'(target_angle);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_x <= '0;
      target_y <= '0;
      target_angle <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr == REG_TARGET_X) target_x <= pwdata;
      if (paddr == REG_TARGET_Y) target_y <= pwdata;
      if (paddr == REG_TARGET_ANGLE) target_angle <= pwdata[24:0];
    end
  end

  // Heading update, small enough to do at acceptance.
  logic signed [25:0] hsum;
  logic signed [25:0] hw;
  logic signed [25:0] da_ext;
  assign da_ext = 26'(in_ch.delta_angle);
  assign hsum = 26'(cur_heading) + da_ext;
  always_comb begin
    hw = hsum;
    if (hsum > 26'(HALF)) hw = hsum - 26'(FULL);
    else if (hsum < -26'(HALF)) hw = hsum + 26'(FULL);
  end
  logic h_upd, l_upd;
  assign h_upd = (da_ext > 26'(ANG_THR)) || (da_ext < -26'(ANG_THR));
  assign l_upd = (in_ch.delta_length > 24'(LEN_THR)) ||
                 (in_ch.delta_length < -24'(LEN_THR));

  logic cstart, cdone, mstart, mdone, qstart, qdone;
  logic signed [31:0] csin, ccos;
  logic signed [23:0] ma;
  logic signed [31:0] mb;
  logic signed [55:0] mprod;
  logic [31:0] root;
  logic signed [26:0] cang;

  generate
    if (FRAC_BITS >= 16) begin : g_shr
      assign cang = 27'(cur_heading >>> (FRAC_BITS - 16));
    end else begin : g_shl
      assign cang = 27'(cur_heading) <<< (16 - FRAC_BITS);
    end
  endgenerate

  opes_cordic u_cordic (.clk, .rst, .start(cstart), .angle(cang), .done(cdone),
                        .sin_out(csin), .cos_out(ccos));
  opes_mul u_mul (.clk, .rst, .start(mstart), .a(ma), .b(mb), .done(mdone),
                  .prod(mprod));
  opes_sqrt u_sqrt (.clk, .rst, .start(qstart), .radicand(sumsq), .done(qdone),
                    .root(root));

  logic out_valid;
  logic mbusy;
  logic signed [32:0] ex_raw, ey_raw, ex_db, ey_db, ax, ay;
  logic signed [32:0] ea_raw, ea_db;
  logic signed [56:0] rnd;
  logic signed [33:0] nx, ny;

  assign ex_raw = 33'(target_x) - 33'(cur_x);
  assign ey_raw = 33'(target_y) - 33'(cur_y);
  assign ea_raw = 33'(target_angle) - 33'(cur_heading);
  assign ex_db = ((ex_raw < 33'(LEN_THR)) && (ex_raw > -33'(LEN_THR))) ? '0 : ex_raw;
  assign ey_db = ((ey_raw < 33'(LEN_THR)) && (ey_raw > -33'(LEN_THR))) ? '0 : ey_raw;
  assign ea_db = ((ea_raw < 33'(ANG_THR)) && (ea_raw > -33'(ANG_THR))) ? '0 : ea_raw;
  assign ax = ex_db[32] ? -ex_db : ex_db;
  assign ay = ey_db[32] ? -ey_db : ey_db;
  assign rnd = (57'(mprod) + 57'sd536870912) >>> 30;
  assign nx = 34'(cur_x) - 34'(rnd);
  assign ny = 34'(cur_y) + 34'(rnd);

  function automatic logic signed [31:0] sat(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic out_load;
  assign out_load = (state == S_OUT) && (!out_valid || (out_ch.valid && out_ch.ready));
  assign in_ch.ready = (state == S_IDLE);
  assign cstart = (state == S_SC) && !mbusy;
  assign mstart = ((state == S_MS) || (state == S_MC) || (state == S_EX) ||
                   (state == S_EY)) && !mbusy;
  assign qstart = (state == S_SQ) && !mbusy;
  always_comb begin
    unique case (state)
      S_MS: begin ma = dl; mb = s_val; end
      S_MC: begin ma = dl; mb = c_val; end
      S_EX: begin ma = 24'(exr); mb = '0; end
      default: begin ma = 24'(eyr); mb = '0; end
    endcase
  end

  // Squares of the errors are formed by a shift-and-add loop in the core, one error after the other.
  logic [31:0] sq_a;
  logic [5:0] sq_cnt;
  logic [63:0] sq_acc, sq_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur_x <= '0;
      cur_y <= '0;
      cur_heading <= '0;
      out_valid <= 1'b0;
      mbusy <= 1'b0;
      sq_cnt <= '0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_ch.valid && out_ch.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            if (h_upd) cur_heading <= hw[24:0];
            dl <= in_ch.delta_length;
            state <= l_upd ? S_SC : S_EX;
            mbusy <= 1'b0;
          end
        end
        S_SC: begin
          if (!mbusy) mbusy <= 1'b1;
          else if (cdone) begin
            s_val <= csin; c_val <= ccos; mbusy <= 1'b0; state <= S_MS;
          end
        end
        S_MS: begin
          if (!mbusy) mbusy <= 1'b1;
          else if (mdone) begin
            cur_x <= sat(nx); mbusy <= 1'b0; state <= S_MC;
          end
        end
        S_MC: begin
          if (!mbusy) mbusy <= 1'b1;
          else if (mdone) begin
            cur_y <= sat(ny); mbusy <= 1'b0; state <= S_EX;
          end
        end
        S_EX: begin
          if (!mbusy) begin
            mbusy <= 1'b1;
            exr <= ax; eyr <= ay;
            backward <= ey_raw > 0;
            big <= ax[31] || ay[31] || ax[32] || ay[32];
            sq_acc <= '0;
            sq_a <= ax[31:0];
            sq_b <= 64'(ax[31:0]);
            sq_cnt <= '0;
          end else begin
            if (sq_a[0]) sq_acc <= sq_acc + sq_b;
            sq_a <= sq_a >> 1;
            sq_b <= sq_b << 1;
            sq_cnt <= sq_cnt + 6'd1;
            if (sq_cnt == 6'd31) begin
              mbusy <= 1'b0; state <= S_EY;
            end
          end
        end
        S_EY: begin
          if (!mbusy) begin
            mbusy <= 1'b1;
            sq_a <= eyr[31:0];
            sq_b <= 64'(eyr[31:0]);
            sq_cnt <= '0;
          end else begin
            if (sq_a[0]) sq_acc <= sq_acc + sq_b;
            sq_a <= sq_a >> 1;
            sq_b <= sq_b << 1;
            sq_cnt <= sq_cnt + 6'd1;
            if (sq_cnt == 6'd31) begin
              sumsq <= (sq_a[0] ? sq_acc + sq_b : sq_acc);
              mbusy <= 1'b0; state <= S_SQ;
            end
          end
        end
        S_SQ: begin
          if (!mbusy) mbusy <= 1'b1;
          else if (qdone) begin
            mbusy <= 1'b0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic signed [32:0] dmag;
  logic signed [31:0] dist_reg;
  logic signed [26:0] ang_reg;
  logic signed [31:0] px, py;
  logic signed [24:0] ph;
  assign dmag = big ? 33'sh080000000 : 33'(root);

  always_ff @(posedge clk) begin
    if (out_load) begin
      dist_reg <= sat(backward ? -34'(dmag) : 34'(dmag));
      ang_reg <= 27'(cur_heading) + 27'(ea_db);
      px <= cur_x; py <= cur_y; ph <= cur_heading;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.drive_distance = dist_reg;
  assign out_ch.drive_angle = ang_reg;
  assign out_ch.pose_x = px;
  assign out_ch.pose_y = py;
  assign out_ch.pose_heading = ph;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> state == S_IDLE) else $error("ready outside idle");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> !in_ch.ready) else $error("accept while busy");
`endif
endmodule

[sim/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the odometry step core.
//
// Targets are programmed over APB between phases while the core is idle. A
// directed table exercises threshold edges and heading wrap; random ticks
// follow under three idling regimes. Every output transaction is compared
// field by field with a behavioural model of the pose update and the drive
// command.
// ----------------------------------------------------------------------------
module tb;
  import opes_pkg::*;

  localparam int F = FRAC_BITS_DEF;
  localparam longint ANG_THR = ((64'sd1 <<< F) + 5) / 10;
  localparam longint LEN_THR = ((64'sd1 <<< F) + 500) / 1000;
  localparam longint DEG90 = 64'sd90 <<< 16;
  localparam longint DEG180 = 64'sd180 <<< F;
  localparam longint DEG360 = 64'sd360 <<< F;
  localparam longint I32MAX = 64'sd2147483647;
  localparam longint I32MIN = -64'sd2147483648;
  localparam int IDLE_CYCLES = 400;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] distance;
    logic signed [26:0] angle;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [24:0] hd;
  } pose_cmd_t;

  typedef struct {
    logic signed [23:0] dl;
    logic signed [24:0] da;
    bit has_exp;
    pose_cmd_t exp_cmd;
  } tick_row_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  opes_in_if in_ch ();
  opes_out_if out_ch ();

  odometry_position_error_step_core DUT (
    .clk(clk), .rst(rst), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  longint tgt_x, tgt_y, tgt_a;
  longint pos_x, pos_y, heading;
  pose_cmd_t expected_cmds[$];
  int errors = 0;
  int ticks_sent = 0;
  int cmds_seen = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  bit [23:0] dl_ones = '0, dl_zeros = '0;
  bit [24:0] da_ones = '0, da_zeros = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint shr(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > I32MAX) return I32MAX;
    if (v < I32MIN) return I32MIN;
    return v;
  endfunction

  function automatic longint labs(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint wrap_deg(longint v);
    longint r;
    r = v % DEG360;
    if (r > DEG180) r -= DEG360;
    else if (r < -DEG180) r += DEG360;
    return r;
  endfunction

  task automatic sin_cos(input longint h, output longint s, output longint c);
    longint z, x, y, xs, ys;
    bit flip;
    x = 64'sd652032874;
    y = 0;
    flip = 0;
    z = shr(h, F - 16);
    if (z > DEG90) begin
      z -= 64'sd180 <<< 16;
      flip = 1;
    end else if (z < -DEG90) begin
      z += 64'sd180 <<< 16;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = shr(x, i);
      ys = shr(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_deg(i[3:0]));
      end else begin
        x += ys; y -= xs; z += longint'(atan_deg(i[3:0]));
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endtask

  function automatic longint root_floor(longint v);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  task automatic advance_pose(input logic signed [23:0] dl, input logic signed [24:0] da,
                              output pose_cmd_t cmd);
    longint d, a, s, c, ex, ey, ea, drv_dist;
    bit backward;
    d = dl;
    a = da;
    if (labs(a) > ANG_THR) heading = wrap_deg(heading + a);
    if (labs(d) > LEN_THR) begin
      sin_cos(heading, s, c);
      pos_x = clamp32(pos_x - shr(d * s + (64'sd1 <<< 29), 30));
      pos_y = clamp32(pos_y + shr(d * c + (64'sd1 <<< 29), 30));
    end
    ex = tgt_x - pos_x;
    ey = tgt_y - pos_y;
    ea = tgt_a - heading;
    backward = ey > 0;
    if (labs(ex) < LEN_THR) ex = 0;
    if (labs(ey) < LEN_THR) ey = 0;
    if (labs(ea) < ANG_THR) ea = 0;
    if (labs(ex) >= (64'sd1 <<< 31) || labs(ey) >= (64'sd1 <<< 31))
      drv_dist = 64'sd1 <<< 31;
    else
      drv_dist = root_floor(ex * ex + ey * ey);
    drv_dist = clamp32(backward ? -drv_dist : drv_dist);
    cmd.distance = drv_dist[31:0];
    cmd.angle = 27'(heading + ea);
    cmd.px = pos_x[31:0];
    cmd.py = pos_y[31:0];
    cmd.hd = heading[24:0];
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch in %s after %0d results: got %0d, expected %0d",
             what, cmds_seen, got, want);
    errors++;
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic set_targets(input longint x, input longint y, input longint a);
    apb_write(REG_TARGET_X, x[31:0]);
    apb_write(REG_TARGET_Y, y[31:0]);
    apb_write(REG_TARGET_ANGLE, 32'(signed'(a[24:0])));
    tgt_x = longint'(signed'(x[31:0]));
    tgt_y = longint'(signed'(y[31:0]));
    tgt_a = longint'(signed'(a[24:0]));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_tick(input logic signed [23:0] dl, input logic signed [24:0] da,
                           input bit has_exp, input pose_cmd_t want);
    pose_cmd_t cmd;
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.delta_length <= dl;
    in_ch.delta_angle <= da;
    do @(posedge clk); while (!in_ch.ready);
    advance_pose(dl, da, cmd);
    if (has_exp && cmd != want) begin
      $display("directed row %0d disagrees with the model", ticks_sent);
      errors++;
    end
    expected_cmds.push_back(cmd);
    dl_ones |= dl; dl_zeros |= ~dl;
    da_ones |= da; da_zeros |= ~da;
    ticks_sent++;
  endtask

  function automatic logic signed [24:0] rand_angle();
    unique case ($urandom_range(3))
      0: return 25'(int'($urandom_range(int'(2 * ANG_THR + 2))) - int'(ANG_THR) - 1);
      1: return 25'(int'($urandom_range(23592960)) - 11796480);
      2: return 25'($urandom);
      default: return 25'(int'($urandom_range(1310720)) - 655360);
    endcase
  endfunction

  function automatic logic signed [23:0] rand_length();
    unique case ($urandom_range(3))
      0: return 24'(int'($urandom_range(int'(2 * LEN_THR + 2))) - int'(LEN_THR) - 1);
      1: return 24'($urandom);
      default: return 24'(int'($urandom_range(1 << 20)) - (1 << 19));
    endcase
  endfunction

  task automatic random_phase(input int n, input int gap, input int stall);
    send_gap_pct = gap;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      send_tick(rand_length(), rand_angle(), 0, '0);
      if (i == n / 2 && gap > 0) begin
        in_ch.valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge clk);
      end
    end
  endtask

  always @(posedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        cmds_seen++;
        if (expected_cmds.size() == 0) begin
          $display("unexpected result transaction");
          errors++;
        end else begin
          pose_cmd_t w;
          w = expected_cmds.pop_front();
          if (out_ch.drive_distance !== w.distance)
            report_mismatch("drive_distance", out_ch.drive_distance, w.distance);
          if (out_ch.drive_angle !== w.angle)
            report_mismatch("drive_angle", out_ch.drive_angle, w.angle);
          if (out_ch.pose_x !== w.px) report_mismatch("pose_x", out_ch.pose_x, w.px);
          if (out_ch.pose_y !== w.py) report_mismatch("pose_y", out_ch.pose_y, w.py);
          if (out_ch.pose_heading !== w.hd)
            report_mismatch("pose_heading", out_ch.pose_heading, w.hd);
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    tick_row_t rows[$];
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.delta_length = '0; in_ch.delta_angle = '0;
    tgt_x = 0; tgt_y = 0; tgt_a = 0;
    pos_x = 0; pos_y = 0; heading = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    rows = '{
      '{24'sd0, 25'sd0, 1, '{32'sd0, 27'sd0, 32'sd0, 32'sd0, 25'sd0}},
      '{24'sd66, 25'sd6554, 1, '{32'sd0, 27'sd0, 32'sd0, 32'sd0, 25'sd0}},
      '{-24'sd66, -25'sd6554, 1, '{32'sd0, 27'sd0, 32'sd0, 32'sd0, 25'sd0}},
      '{24'sd67, 25'sd6555, 0, '0},
      '{24'sd8388607, 25'sd11796480, 0, '0},
      '{-24'sd8388608, -25'sd11796480, 0, '0},
      '{24'sd8388607, 25'sd5898240, 0, '0},
      '{24'sd8388607, -25'sd11796480, 0, '0},
      '{-24'sd8388608, 25'sd11796479, 0, '0},
      '{24'sd65536, -25'sd16777216, 0, '0},
      '{24'sd65536, 25'sd16777215, 0, '0},
      '{-24'sd65536, 25'sd5898240, 0, '0}
    };
    foreach (rows[i]) send_tick(rows[i].dl, rows[i].da, rows[i].has_exp, rows[i].exp_cmd);
    for (int i = 0; i < 8; i++) send_tick(24'sd8388607, 25'sd0, 0, '0);
    drain();

    set_targets(I32MAX, I32MIN, 11796480);
    send_tick(24'sd0, 25'sd0, 0, '0);
    random_phase(400, 7, 51);
    drain();

    set_targets(I32MIN, I32MAX, -11796480);
    send_tick(-24'sd8388608, 25'sd0, 0, '0);
    random_phase(400, 51, 7);
    drain();

    set_targets(longint'($urandom_range(1 << 22)) - (1 << 21),
                longint'($urandom_range(1 << 22)) - (1 << 21), 0);
    random_phase(400, 0, 0);
    drain();

    $display("%0d ticks sent, %0d result transactions checked over four target settings",
             ticks_sent, cmds_seen);
    $display("input bit toggles complete: %0b", (&dl_ones) && (&dl_zeros) &&
             (&da_ones) && (&da_zeros));
    if (errors == 0 && expected_cmds.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
